[rtl/mfd_pkg.sv]
// Shared types and constants for the serial frame deframer.
// Result record, event codes, register reset value and the CRC-16 X.25 step.
// No dependencies.
package mfd_pkg;

    localparam logic [7:0]  START_BYTE_RESET = 8'h55;
    localparam logic [15:0] CRC_PRESET       = 16'hFFFF;

    typedef enum logic [2:0] {
        EV_IDLE    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BAD_LO  = 3'd4,
        EV_BAD_HI  = 3'd5
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_len;
        logic [7:0] frame_seq;
        logic [7:0] frame_sys;
        logic [7:0] frame_comp;
        logic [7:0] frame_msgid;
    } res_t;

    // One byte of CRC-16 X.25 (reflected 0x8408), byte-wide form
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] t;
        t = data ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

[rtl/mfd_parser.sv]
// Frame parser state machine: header capture, payload indexing, CRC check.
// Depends on mfd_pkg. Result for the byte is formed combinationally.
module mfd_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    start_byte,
    input  logic          take,
    input  logic [7:0]    rx_byte,
    output mfd_pkg::res_t res
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN     = 4'd1,
        PH_SEQ     = 4'd2,
        PH_SYS     = 4'd3,
        PH_COMP    = 4'd4,
        PH_MSGID   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_CRC_HI  = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  comp_reg, comp_next;
    logic [7:0]  msgid_reg, msgid_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] crc_upd;
    logic        is_start;
    mfd_pkg::event_t ev;
    logic [7:0]  pb;
    logic [7:0]  pi;

    assign crc_upd  = mfd_pkg::crc_step(crc_reg, rx_byte);
    assign is_start = (rx_byte == start_byte);

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        sys_next   = sys_reg;
        comp_next  = comp_reg;
        msgid_next = msgid_reg;
        idx_next   = idx_reg;
        ev         = mfd_pkg::EV_IDLE;
        pb         = 8'h00;
        pi         = 8'h00;
        case (phase_reg)
            PH_LEN:
            begin
                len_next   = rx_byte;
                idx_next   = 8'h00;
                crc_next   = crc_upd;
                phase_next = PH_SEQ;
                ev         = mfd_pkg::EV_HEADER;
            end
            PH_SEQ:
            begin
                seq_next   = rx_byte;
                crc_next   = crc_upd;
                phase_next = PH_SYS;
                ev         = mfd_pkg::EV_HEADER;
            end
            PH_SYS:
            begin
                sys_next   = rx_byte;
                crc_next   = crc_upd;
                phase_next = PH_COMP;
                ev         = mfd_pkg::EV_HEADER;
            end
            PH_COMP:
            begin
                comp_next  = rx_byte;
                crc_next   = crc_upd;
                phase_next = PH_MSGID;
                ev         = mfd_pkg::EV_HEADER;
            end
            PH_MSGID:
            begin
                msgid_next = rx_byte;
                crc_next   = crc_upd;
                phase_next = (len_reg == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                ev         = mfd_pkg::EV_HEADER;
            end
            PH_PAYLOAD:
            begin
                pb       = rx_byte;
                pi       = idx_reg;
                crc_next = crc_upd;
                idx_next = idx_reg + 8'd1;
                if (idx_next == len_reg)
                begin
                    phase_next = PH_CRC_LO;
                end
                ev = mfd_pkg::EV_PAYLOAD;
            end
            PH_CRC_LO:
            begin
                if (rx_byte != crc_reg[7:0])
                begin
                    ev = mfd_pkg::EV_BAD_LO;
                    // bad byte may itself open the next frame
                    if (is_start)
                    begin
                        phase_next = PH_LEN;
                        crc_next   = mfd_pkg::CRC_PRESET;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    phase_next = PH_CRC_HI;
                    ev         = mfd_pkg::EV_HEADER;
                end
            end
            PH_CRC_HI:
            begin
                if (rx_byte != crc_reg[15:8])
                begin
                    ev = mfd_pkg::EV_BAD_HI;
                    if (is_start)
                    begin
                        phase_next = PH_LEN;
                        crc_next   = mfd_pkg::CRC_PRESET;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    ev         = mfd_pkg::EV_GOOD;
                end
            end
            default:
            begin
                if (is_start)
                begin
                    phase_next = PH_LEN;
                    crc_next   = mfd_pkg::CRC_PRESET;
                    ev         = mfd_pkg::EV_HEADER;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            crc_reg   <= mfd_pkg::CRC_PRESET;
            len_reg   <= 8'h00;
            seq_reg   <= 8'h00;
            sys_reg   <= 8'h00;
            comp_reg  <= 8'h00;
            msgid_reg <= 8'h00;
            idx_reg   <= 8'h00;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            sys_reg   <= sys_next;
            comp_reg  <= comp_next;
            msgid_reg <= msgid_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        res.event_res     = ev;
        res.payload_byte  = pb;
        res.payload_index = pi;
        res.frame_len     = len_next;
        res.frame_seq     = seq_next;
        res.frame_sys     = sys_next;
        res.frame_comp    = comp_next;
        res.frame_msgid   = msgid_next;
    end

endmodule

[rtl/mfd_skid.sv]
// Result register with a skid entry behind it.
// Depends on mfd_pkg. Input stalls only when the skid entry is occupied.
module mfd_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mfd_pkg::res_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output mfd_pkg::res_t out_data
);

    logic          main_valid_reg;
    logic          skid_valid_reg;
    mfd_pkg::res_t main_reg;
    mfd_pkg::res_t skid_reg;
    logic          push;
    logic          pop;

    assign in_stall  = skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= in_data;
            end
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

endmodule

[rtl/mavlink_frame_deframer_top.sv]
// Serial frame deframer top level: start byte register, parser, result buffer.
// Depends on mfd_pkg, mfd_parser and mfd_skid.
// Each result is registered in the result buffer (via the skid entry if held) before res_valid shows it.
// Throughput: one byte per cycle while rx_stall is low; the parser state and CRC step are combinational.
// Two-entry result buffer: rx_stall rises only once a stalled result has a second behind it.
// Reset (rst_n low, asynchronous) returns to hunting, presets the CRC to 0xFFFF,
// clears the header fields and sets the start byte to 0x55.
module mavlink_frame_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] event_res,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_len,
    output logic [7:0] frame_seq,
    output logic [7:0] frame_sys,
    output logic [7:0] frame_comp,
    output logic [7:0] frame_msgid
);

    logic [7:0]    start_byte_reg;
    logic          take;
    mfd_pkg::res_t parse_res;
    mfd_pkg::res_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= mfd_pkg::START_BYTE_RESET;
        end
        else if (cfg_wr_en)
        begin
            start_byte_reg <= cfg_wr_data;
        end
    end

    assign take = rx_valid && !rx_stall;

    mfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_byte (start_byte_reg),
        .take       (take),
        .rx_byte    (rx_byte),
        .res        (parse_res)
    );

    mfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_valid),
        .in_stall  (rx_stall),
        .in_data   (parse_res),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_data  (out_res)
    );

    assign event_res     = out_res.event_res;
    assign payload_byte  = out_res.payload_byte;
    assign payload_index = out_res.payload_index;
    assign frame_len     = out_res.frame_len;
    assign frame_seq     = out_res.frame_seq;
    assign frame_sys     = out_res.frame_sys;
    assign frame_comp    = out_res.frame_comp;
    assign frame_msgid   = out_res.frame_msgid;

endmodule
